/* rtl/brz_pkg.sv */
// Shared types and constants for the Bresenham line rasterizer.
package brz_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COLOUR_W       = 24;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_W    = 1;
    localparam int QUEUE_CNT_W    = 2;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TICK = 1'b1
    } t_req_e;

    // Back-end status seen by the top level.
    typedef struct packed {
        logic busy;
        logic pop_load;
        logic pop_tick;
        logic tick_last;
    } t_back_status;

endpackage

/* rtl/brz_front.sv */
// Front end: decodes stream transactions into queue commands, precomputes spans.
module brz_front #(
    parameter int COORD_BITS = brz_pkg::COORD_BITS_DEF,
    parameter int IN_TDATA_W = 72,
    parameter int CMD_W      = 1 + 6 * COORD_BITS + 2 + brz_pkg::COLOUR_W
) (
    input  logic                  i_s_tvalid,
    input  logic [IN_TDATA_W-1:0] i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic                  i_queue_full,
    output logic                  o_s_tready,
    output logic                  o_push,
    output logic [CMD_W-1:0]      o_cmd
);

    localparam int CB = COORD_BITS;
    localparam int CW = brz_pkg::COLOUR_W;

    logic [CB-1:0] x0, y0, x1, y1, span_x, span_y;
    logic [CW-1:0] colour;
    logic          dir_x_neg, dir_y_neg, is_load;

    assign x0     = i_s_tdata[CB-1:0];
    assign y0     = i_s_tdata[2*CB-1:CB];
    assign x1     = i_s_tdata[3*CB-1:2*CB];
    assign y1     = i_s_tdata[4*CB-1:3*CB];
    assign colour = i_s_tdata[4*CB+CW-1:4*CB];

    assign is_load   = (brz_pkg::t_req_e'(i_s_tuser) == brz_pkg::REQ_LOAD);
    assign dir_x_neg = (x1 < x0);
    assign dir_y_neg = (y1 < y0);
    assign span_x    = dir_x_neg ? (x0 - x1) : (x1 - x0);
    assign span_y    = dir_y_neg ? (y0 - y1) : (y1 - y0);

    assign o_s_tready = !i_queue_full;
    assign o_push     = i_s_tvalid && !i_queue_full;
    assign o_cmd      = {is_load, x0, y0, x1, y1, span_x, span_y,
                         dir_x_neg, dir_y_neg, colour};

endmodule

/* rtl/brz_queue.sv */
// Two-entry command queue between the front end and the stepper.
module brz_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid,
    output logic             o_full
);

    logic [WIDTH-1:0]                r_mem [brz_pkg::QUEUE_DEPTH];
    logic [brz_pkg::QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [brz_pkg::QUEUE_CNT_W-1:0] r_count;
    logic                            do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == brz_pkg::QUEUE_CNT_W'(brz_pkg::QUEUE_DEPTH));
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && do_pop) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

/* rtl/brz_back.sv */
// Back end: Bresenham stepper with a registered pixel output stage.
module brz_back #(
    parameter int COORD_BITS = brz_pkg::COORD_BITS_DEF,
    parameter int CMD_W      = 1 + 6 * COORD_BITS + 2 + brz_pkg::COLOUR_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  logic [CMD_W-1:0]              i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [COORD_BITS-1:0]         o_pixel_x,
    output logic [COORD_BITS-1:0]         o_pixel_y,
    output logic [brz_pkg::COLOUR_W-1:0]  o_pixel_colour,
    output logic                          o_last_pixel,
    output brz_pkg::t_back_status         o_status
);

    localparam int CB = COORD_BITS;
    localparam int CW = brz_pkg::COLOUR_W;
    localparam int EW = CB + 2;
    localparam int TW = CB + 3;

    // command fields
    logic          c_load, c_dxn, c_dyn;
    logic [CB-1:0] c_x0, c_y0, c_x1, c_y1, c_sx, c_sy;
    logic [CW-1:0] c_colour;

    assign {c_load, c_x0, c_y0, c_x1, c_y1, c_sx, c_sy, c_dxn, c_dyn, c_colour} = i_cmd;

    logic [CB-1:0]        r_cur_col, r_cur_row, r_tgt_col, r_tgt_row, r_span_x, r_span_y;
    logic [CB-1:0]        n_cur_col, n_cur_row, n_tgt_col, n_tgt_row, n_span_x, n_span_y;
    logic signed [EW-1:0] r_err, n_err;
    logic                 r_dxn, r_dyn, r_busy, n_dxn, n_dyn, n_busy;
    logic [CW-1:0]        r_colour, n_colour;
    logic                 r_out_valid, n_out_valid;
    logic [CB-1:0]        r_out_x, r_out_y, n_out_x, n_out_y;
    logic [CW-1:0]        r_out_colour, n_out_colour;
    logic                 r_out_last, n_out_last;

    logic                 pop, at_last, step_x, step_y;
    logic signed [TW-1:0] twice, neg_sy, pos_sx;

    assign o_cmd_pop = !r_out_valid || i_m_tready;
    assign pop       = i_cmd_valid && o_cmd_pop;
    assign at_last   = (r_cur_col == r_tgt_col) && (r_cur_row == r_tgt_row);

    assign twice  = {r_err, 1'b0};
    assign pos_sx = $signed({3'b000, r_span_x});
    assign neg_sy = -$signed({3'b000, r_span_y});
    assign step_x = (twice >= neg_sy);
    assign step_y = (twice <= pos_sx);

    always_comb begin
        n_cur_col    = r_cur_col;
        n_cur_row    = r_cur_row;
        n_tgt_col    = r_tgt_col;
        n_tgt_row    = r_tgt_row;
        n_span_x     = r_span_x;
        n_span_y     = r_span_y;
        n_err        = r_err;
        n_dxn        = r_dxn;
        n_dyn        = r_dyn;
        n_busy       = r_busy;
        n_colour     = r_colour;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_colour = r_out_colour;
        n_out_last   = r_out_last;
        if (pop) begin
            if (c_load) begin
                n_cur_col = c_x0;
                n_cur_row = c_y0;
                n_tgt_col = c_x1;
                n_tgt_row = c_y1;
                n_span_x  = c_sx;
                n_span_y  = c_sy;
                n_dxn     = c_dxn;
                n_dyn     = c_dyn;
                n_err     = $signed({2'b00, c_sx}) - $signed({2'b00, c_sy});
                n_colour  = c_colour;
                n_busy    = 1'b1;
            end else if (r_busy) begin
                n_out_valid  = 1'b1;
                n_out_x      = r_cur_col;
                n_out_y      = r_cur_row;
                n_out_colour = r_colour;
                n_out_last   = at_last;
                if (at_last) begin
                    n_busy = 1'b0;
                end else begin
                    if (step_x && step_y) begin
                        n_err = r_err - $signed({2'b00, r_span_y})
                                      + $signed({2'b00, r_span_x});
                    end else if (step_x) begin
                        n_err = r_err - $signed({2'b00, r_span_y});
                    end else if (step_y) begin
                        n_err = r_err + $signed({2'b00, r_span_x});
                    end
                    if (step_x) n_cur_col = r_dxn ? r_cur_col - 1'b1 : r_cur_col + 1'b1;
                    if (step_y) n_cur_row = r_dyn ? r_cur_row - 1'b1 : r_cur_row + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_tgt_col   <= '0;
            r_tgt_row   <= '0;
            r_span_x    <= '0;
            r_span_y    <= '0;
            r_err       <= '0;
            r_dxn       <= 1'b0;
            r_dyn       <= 1'b0;
            r_colour    <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_tgt_col   <= n_tgt_col;
            r_tgt_row   <= n_tgt_row;
            r_span_x    <= n_span_x;
            r_span_y    <= n_span_y;
            r_err       <= n_err;
            r_dxn       <= n_dxn;
            r_dyn       <= n_dyn;
            r_colour    <= n_colour;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_x      <= n_out_x;
        r_out_y      <= n_out_y;
        r_out_colour <= n_out_colour;
        r_out_last   <= n_out_last;
    end

    assign o_m_tvalid     = r_out_valid;
    assign o_pixel_x      = r_out_x;
    assign o_pixel_y      = r_out_y;
    assign o_pixel_colour = r_out_colour;
    assign o_last_pixel   = r_out_last;

    assign o_status.busy      = r_busy;
    assign o_status.pop_load  = pop && c_load;
    assign o_status.pop_tick  = pop && !c_load;
    assign o_status.tick_last = pop && !c_load && r_busy && at_last;

endmodule

/* rtl/bresenham_line_rasterizer_unit.sv */
// A tick transaction passes through the queue and the registered output stage before
// its pixel shows on m_axis; a load transaction produces no output.
// Throughput: one transaction per cycle; the stepper's single add/compare loop
// on the error term sets it, and a full output stage with tready low stalls it.
// Reset: synchronous, active low; clears the queue, the output stage and the
// line state, leaving the unit idle.
module bresenham_line_rasterizer_unit #(
    parameter int COORD_BITS = brz_pkg::COORD_BITS_DEF,
    localparam int IN_W       = 4 * COORD_BITS + brz_pkg::COLOUR_W,
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W      = 2 * COORD_BITS + brz_pkg::COLOUR_W,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side: line loads and pixel ticks
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: start_x, start_y, end_x, end_y, line_colour (from bit 0), zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: req_type (0 = load, 1 = tick)
    input  logic                   s_axis_tuser,
    // master side: emitted pixels
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: pixel_x, pixel_y, pixel_colour (from bit 0), zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // tlast: last_pixel
    output logic                   m_axis_tlast
);

    localparam int CMD_W = 1 + 6 * COORD_BITS + 2 + brz_pkg::COLOUR_W;

    logic                          push, q_full, q_valid, q_pop;
    logic [CMD_W-1:0]              cmd_in, cmd_out;
    logic [COORD_BITS-1:0]         pix_x, pix_y;
    logic [brz_pkg::COLOUR_W-1:0]  pix_colour;
    brz_pkg::t_back_status         status;

    // Front end classifies each transaction and precomputes spans and directions.
    brz_front #(
        .COORD_BITS (COORD_BITS),
        .IN_TDATA_W (IN_TDATA_W),
        .CMD_W      (CMD_W)
    ) u_front (
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_queue_full (q_full),
        .o_s_tready   (s_axis_tready),
        .o_push       (push),
        .o_cmd        (cmd_in)
    );

    // Short queue decouples input acceptance from output backpressure.
    brz_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .i_pop   (q_pop),
        .o_data  (cmd_out),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    // Stepper: one Bresenham step per tick, results into the output register.
    brz_back #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .i_cmd          (cmd_out),
        .o_cmd_pop      (q_pop),
        .o_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .o_pixel_x      (pix_x),
        .o_pixel_y      (pix_y),
        .o_pixel_colour (pix_colour),
        .o_last_pixel   (m_axis_tlast),
        .o_status       (status)
    );

    assign m_axis_tdata = OUT_TDATA_W'({pix_colour, pix_y, pix_x});

    // A loaded line makes the stepper busy.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.pop_load |=> status.busy)
        else $error("load did not start a line");

    // Emitting the end pixel ends the line.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.tick_last |=> !status.busy)
        else $error("line still active after its end pixel");

    // A tick taken while idle produces no pixel.
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.pop_tick && !status.busy) |=> !m_axis_tvalid)
        else $error("pixel emitted for a tick while idle");

    // Any pixel appearing fresh comes from a popped tick while busy.
    a_pixel_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(status.pop_tick && status.busy))
        else $error("pixel without a tick");

endmodule

/* dv/bresenham_line_checker.sv */
// Pixel checker: predicts rasterized pixels from accepted transactions and compares outputs.
`timescale 1ns / 100ps

module bresenham_line_checker
    import brz_pkg::*;
#(
    parameter int CW          = brz_pkg::COORD_BITS_DEF,
    parameter int IN_TDATA_W  = 72,
    parameter int OUT_TDATA_W = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    input  logic                   i_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                   i_s_axis_tuser,
    input  logic                   i_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_axis_tdata,
    input  logic                   i_m_axis_tlast,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [CW-1:0]       col;
        logic [CW-1:0]       row;
        logic [COLOUR_W-1:0] colour;
        logic                last;
    } t_pixel;

    // pixels owed by the rasterizer, oldest first
    t_pixel pixels_due[$];

    // line walker state
    logic [CW-1:0]       walk_col, walk_row;
    logic [CW-1:0]       dest_col, dest_row;
    logic [CW-1:0]       run_x, run_y;
    logic signed [CW+1:0] slope_err;
    logic                step_left, step_up;
    logic                line_active;
    logic [COLOUR_W-1:0] line_colour;

    task automatic report_pixel(input string what, input t_pixel want, input t_pixel got);
        string got_txt;
        o_fail_count++;
        if (o_fail_count <= 10) begin
            got_txt = $sformatf("x=%0d y=%0d colour=%06h last=%0b",
                                got.col, got.row, got.colour, got.last);
            $display("%0t pixel %s: expected x=%0d y=%0d colour=%06h last=%0b, got %s",
                     $realtime, what, want.col, want.row, want.colour, want.last, got_txt);
        end
    endtask

    // one Bresenham step; both axes may move on the same step
    task automatic step_line();
        int e2;
        int err_now;
        int sx;
        int sy;
        err_now = int'(slope_err);
        sx      = int'(run_x);
        sy      = int'(run_y);
        e2      = 2 * err_now;
        if (e2 >= -sy) begin
            err_now -= sy;
            walk_col = step_left ? walk_col - 1'b1 : walk_col + 1'b1;
        end
        if (e2 <= sx) begin
            err_now += sx;
            walk_row = step_up ? walk_row - 1'b1 : walk_row + 1'b1;
        end
        slope_err = err_now[CW+1:0];
    endtask

    task automatic take_request(input logic req, input logic [IN_TDATA_W-1:0] data);
        logic [CW-1:0] x0, y0, x1, y1;
        t_pixel        px;
        x0 = data[CW-1:0];
        y0 = data[2*CW-1:CW];
        x1 = data[3*CW-1:2*CW];
        y1 = data[4*CW-1:3*CW];
        if (req == REQ_LOAD) begin
            // a load replaces whatever line is running
            walk_col    = x0;
            walk_row    = y0;
            dest_col    = x1;
            dest_row    = y1;
            run_x       = (x1 >= x0) ? x1 - x0 : x0 - x1;
            run_y       = (y1 >= y0) ? y1 - y0 : y0 - y1;
            step_left   = (x1 < x0);
            step_up     = (y1 < y0);
            slope_err   = $signed({2'b00, run_x}) - $signed({2'b00, run_y});
            line_colour = data[4*CW+COLOUR_W-1:4*CW];
            line_active = 1'b1;
        end else if (line_active) begin
            px.col    = walk_col;
            px.row    = walk_row;
            px.colour = line_colour;
            px.last   = (walk_col == dest_col) && (walk_row == dest_row);
            pixels_due.push_back(px);
            if (px.last)
                line_active = 1'b0;
            else
                step_line();
        end
        // ticks with no active line are dropped silently
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        line_active  = 1'b0;
    end

    always @(posedge i_clk) begin
        t_pixel got;
        t_pixel want;
        if (!i_rst_n) begin
            walk_col    = '0;
            walk_row    = '0;
            dest_col    = '0;
            dest_row    = '0;
            run_x       = '0;
            run_y       = '0;
            slope_err   = '0;
            step_left   = 1'b0;
            step_up     = 1'b0;
            line_colour = '0;
            line_active = 1'b0;
            pixels_due.delete();
        end else begin
            // output side first: a pixel leaving now was owed by an earlier tick
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.col    = i_m_axis_tdata[CW-1:0];
                got.row    = i_m_axis_tdata[2*CW-1:CW];
                got.colour = i_m_axis_tdata[2*CW+COLOUR_W-1:2*CW];
                got.last   = i_m_axis_tlast;
                if (pixels_due.size() == 0) begin
                    report_pixel("unexpected", '0, got);
                end else begin
                    want = pixels_due.pop_front();
                    if (want.col != got.col || want.row != got.row ||
                        want.colour != got.colour || want.last != got.last)
                        report_pixel("mismatch", want, got);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                take_request(i_s_axis_tuser, i_s_axis_tdata);
        end
        o_pending = pixels_due.size();
    end

endmodule

/* dv/tb_bresenham_line_rasterizer_unit.sv */
// Testbench top for the Bresenham line rasterizer: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_bresenham_line_rasterizer_unit;
    import brz_pkg::*;

    localparam int CW          = COORD_BITS_DEF;
    localparam int IN_W        = 4 * CW + COLOUR_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 2 * CW + COLOUR_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int COORD_MAX   = (1 << CW) - 1;
    localparam int COLOUR_MAX  = (1 << COLOUR_W) - 1;

    localparam int ITEM_TARGET = 650;
    localparam int QUIET_FROM  = 560;   // no idling on either side past this point
    localparam int STALL_LIMIT = 2000;  // cycles with no transaction on either side
    localparam int DRAIN_TAIL  = 16;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // tdata: start_x, start_y, end_x, end_y, line_colour (from bit 0), zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // tuser: req_type
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // tdata: pixel_x, pixel_y, pixel_colour (from bit 0), zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // tlast: last_pixel
    logic                   m_axis_tlast;

    int fail_count;
    int pixels_pending;
    int items_sent;
    bit quiet;     // end of run: both sides stream without gaps
    bit calm_tx;   // current line is sent back to back

    bresenham_line_rasterizer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    bresenham_line_checker #(
        .CW          (CW),
        .IN_TDATA_W  (IN_TDATA_W),
        .OUT_TDATA_W (OUT_TDATA_W)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pixels_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Sender helpers. Everything is driven at the falling edge and each
    // transaction completes on the rising edge where tvalid and tready meet.
    // ------------------------------------------------------------------

    // Drive one transaction, possibly after a random idle burst.
    task automatic send_item(input t_req_e req, input logic [IN_TDATA_W-1:0] data);
        int gap;
        if (!quiet && !calm_tx && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic load_line(input int x0, input int y0, input int x1, input int y1,
                             input int colour);
        logic [IN_TDATA_W-1:0] data;
        data = '0;
        data[IN_W-1:0] = {colour[COLOUR_W-1:0], y1[CW-1:0], x1[CW-1:0],
                          y0[CW-1:0], x0[CW-1:0]};
        send_item(REQ_LOAD, data);
    endtask

    // Ticks carry junk in tdata; the rasterizer must ignore it.
    task automatic tick_pixels(input int count);
        logic [95:0] junk;
        repeat (count) begin
            junk = {$urandom, $urandom, $urandom};
            send_item(REQ_TICK, junk[IN_TDATA_W-1:0]);
        end
    endtask

    // Hold the input side off until every owed pixel has come out.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pixels_pending != 0) @(negedge i_clk);
    endtask

    // Coordinate biased toward the edges of the raster.
    function automatic int pick_coord();
        int zone;
        zone = $urandom_range(0, 3);
        if (zone == 0)
            return $urandom_range(0, 3);
        else if (zone == 1)
            return $urandom_range(COORD_MAX - 3, COORD_MAX);
        return $urandom_range(0, COORD_MAX);
    endfunction

    // Nearby second endpoint, kept inside the raster, either direction.
    function automatic int near_coord(input int c);
        int d;
        d = $urandom_range(0, 12);
        if ($urandom_range(0, 1) == 1)
            return (c + d <= COORD_MAX) ? c + d : c - d;
        return (c >= d) ? c - d : c + d;
    endfunction

    // ------------------------------------------------------------------
    // Output side: tready drops in random bursts, with
    // stretches where bursts are switched off.
    // ------------------------------------------------------------------
    initial begin
        int hold;
        int cyc;
        bit calm_rx;
        m_axis_tready = 1'b0;
        hold    = 0;
        cyc     = 0;
        calm_rx = 1'b0;
        forever begin
            @(negedge i_clk);
            if (cyc % 64 == 0)
                calm_rx = ($urandom_range(0, 2) == 0);
            cyc++;
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else if (!quiet && !calm_rx && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                hold = $urandom_range(1, 9) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when no transaction moves for too long.
    // ------------------------------------------------------------------
    initial begin
        int stalled;
        stalled = 0;
        @(posedge i_rst_n);
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stalled = 0;
            else
                stalled++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------
    initial begin
        int x0, y0, x1, y1;
        int span_x, span_y, ticks, shape;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = REQ_LOAD;
        s_axis_tdata  = '0;
        items_sent    = 0;
        quiet         = 1'b0;
        calm_tx       = 1'b0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        // tick with no line loaded: dropped
        tick_pixels(1);
        // full-diagonal line at the raster corners, cut short by the next load
        load_line(0, 0, COORD_MAX, COORD_MAX, COLOUR_MAX);
        tick_pixels(3);
        // reverse diagonal replaces the running line mid-walk
        load_line(COORD_MAX, COORD_MAX, 0, 0, 0);
        tick_pixels(3);
        // single-point line: first tick is also the last pixel, second is idle
        load_line(COORD_MAX, 0, COORD_MAX, 0, 24'h5A5A5A);
        tick_pixels(2);
        // horizontal, stepping left
        load_line(3, 7, 0, 7, 24'hA5A5A5);
        tick_pixels(4);
        // vertical, stepping down
        load_line(5, 0, 5, 2, 24'h0F0F0F);
        tick_pixels(3);
        wait_drained();

        // Random part: mostly complete short lines in all octants, some
        // wide lines cut short, some lines interrupted, idle ticks as noise.
        while (items_sent < ITEM_TARGET) begin
            quiet   = (items_sent >= QUIET_FROM);
            calm_tx = ($urandom_range(0, 3) == 0);
            shape   = $urandom_range(0, 7);
            if (shape == 0) begin
                x0    = $urandom_range(0, COORD_MAX);
                y0    = $urandom_range(0, COORD_MAX);
                x1    = $urandom_range(0, COORD_MAX);
                y1    = $urandom_range(0, COORD_MAX);
                ticks = $urandom_range(1, 24);
            end else begin
                x0     = pick_coord();
                y0     = pick_coord();
                x1     = near_coord(x0);
                y1     = near_coord(y0);
                span_x = (x1 > x0) ? x1 - x0 : x0 - x1;
                span_y = (y1 > y0) ? y1 - y0 : y0 - y1;
                ticks  = ((span_x > span_y) ? span_x : span_y) + 1;
                if (shape == 1)
                    ticks = $urandom_range(0, ticks);   // new load lands mid-line
                else
                    ticks += $urandom_range(0, 2);      // trailing ticks hit an idle unit
            end
            load_line(x0, y0, x1, y1, $urandom_range(0, COLOUR_MAX));
            tick_pixels(ticks);
            if (!quiet && $urandom_range(0, 24) == 0)
                wait_drained();
        end

        // Wind down: let the output side empty, then a short tail.
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pixels_pending != 0) @(negedge i_clk);
        repeat (DRAIN_TAIL) @(negedge i_clk);

        if (fail_count == 0 && pixels_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/brz_pkg.sv
rtl/brz_front.sv
rtl/brz_queue.sv
rtl/brz_back.sv
rtl/bresenham_line_rasterizer_unit.sv
dv/bresenham_line_checker.sv
dv/tb_bresenham_line_rasterizer_unit.sv
